// ===== sv/dcm_pkg.sv =====
package dcm_pkg;

   localparam int unsigned PWM_STEPS = 10;

   localparam logic [7:0]  KEY_MAX_SPEED = 8'd7;
   localparam logic [7:0]  KEY_STAR      = 8'd42;
   localparam logic [7:0]  KEY_HASH      = 8'd35;
   localparam logic [7:0]  KEY_A         = 8'd65;

   localparam logic        FUNC_KEY      = 1'b0;
   localparam logic        FUNC_TICK     = 1'b1;

   localparam logic [6:0]  SPEED_STEP    = 7'd10;
   localparam logic [6:0]  SPEED_MAX     = 7'd100;
   localparam logic [15:0] RAMP_RESET    = 16'd200;

   typedef struct packed {
      logic       func;
      logic [7:0] key_code;
   } item_type;

   typedef struct packed {
      logic [2:0] drive_pins;
      logic [6:0] target_speed;
      logic [6:0] ramped_speed;
      logic       spin_reverse;
      logic       smooth_on;
   } result_type;

   // speed / 10 for speeds below 128: multiply by 205, shift by 11
   function automatic logic [3:0] speed_div10(input logic [6:0] spd);
      logic [14:0] prod;
      prod = 15'(spd) * 15'd205;
      return prod[14:11];
   endfunction

   // target speed for a numeric key: 0 stops, else 30 + 10 * key
   function automatic logic [6:0] goal_for_key(input logic [2:0] key);
      logic [6:0] goal;
      case (key)
         3'd0:    goal = 7'd0;
         3'd1:    goal = 7'd40;
         3'd2:    goal = 7'd50;
         3'd3:    goal = 7'd60;
         3'd4:    goal = 7'd70;
         3'd5:    goal = 7'd80;
         3'd6:    goal = 7'd90;
         default: goal = 7'd100;
      endcase
      return goal;
   endfunction

endpackage

// ===== sv/dcm_if.sv =====
interface dcm_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] key_code;

   modport source (output valid, output func, output key_code, input ready);
   modport sink   (input valid, input func, input key_code, output ready);
endinterface

interface dcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] drive_pins;
   logic [6:0] target_speed;
   logic [6:0] ramped_speed;
   logic       spin_reverse;
   logic       smooth_on;

   modport source (output valid, output drive_pins, output target_speed,
                   output ramped_speed, output spin_reverse, output smooth_on,
                   input ready);
   modport sink   (input valid, input drive_pins, input target_speed,
                   input ramped_speed, input spin_reverse, input smooth_on,
                   output ready);
endinterface

interface dcm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] ramp_interval;

   modport source (output valid, output ramp_interval, input ready);
   modport sink   (input valid, input ramp_interval, output ready);
endinterface

// ===== sv/dcm_in_stage.sv =====
module dcm_in_stage (
   input  logic              clock,
   input  logic              reset,
   dcm_req_if.sink           req_bus,
   input  logic              take,
   output logic              item_valid,
   output dcm_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   dcm_pkg::item_type item_ff;
   logic              load;

   assign req_bus.ready = !valid_ff || take;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.func     <= req_bus.func;
         item_ff.key_code <= req_bus.key_code;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/dcm_core.sv =====
module dcm_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  dcm_pkg::item_type item,
   output logic              take,
   dcm_csr_if.sink           csr_bus,
   dcm_rsp_if.source         rsp_bus
);

   localparam logic [4:0] PhaseWrap = 5'(dcm_pkg::PWM_STEPS);

   logic [15:0] interval_ff;
   logic [6:0]  goal_ff, goal_in;
   logic        dir_now_ff, dir_now_in;
   logic        dir_before_ff, dir_before_in;
   logic        smooth_ff, smooth_in;
   logic [6:0]  soft_ff, soft_in;
   logic        rev_ff, rev_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  phase_ff, phase_in;

   logic                out_valid_ff;
   dcm_pkg::result_type out_ff, out_in;

   logic [15:0] tick_inc;
   logic [4:0]  phase_inc;
   logic        want_dir;
   logic [6:0]  spd;
   logic        pwm;
   logic        active;
   logic        lvl_dir;

   assign csr_bus.ready = 1'b1;
   assign take = item_valid && (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      goal_in       = goal_ff;
      dir_now_in    = dir_now_ff;
      dir_before_in = dir_before_ff;
      smooth_in     = smooth_ff;
      soft_in       = soft_ff;
      rev_in        = rev_ff;
      tick_in       = tick_ff;
      phase_in      = phase_ff;
      tick_inc      = tick_ff + 16'd1;
      phase_inc     = 5'(phase_ff) + 5'd1;
      want_dir      = (item.key_code == dcm_pkg::KEY_HASH);

      if (item.func == dcm_pkg::FUNC_KEY) begin
         if (item.key_code <= dcm_pkg::KEY_MAX_SPEED) begin
            if (smooth_ff) begin
               soft_in = goal_ff;
            end
            goal_in = dcm_pkg::goal_for_key(item.key_code[2:0]);
         end else if (item.key_code == dcm_pkg::KEY_STAR ||
                      item.key_code == dcm_pkg::KEY_HASH) begin
            if (!smooth_ff) begin
               dir_now_in = want_dir;
            end else if (dir_before_ff != want_dir) begin
               soft_in       = goal_ff;
               rev_in        = 1'b1;
               dir_before_in = dir_now_ff;
               dir_now_in    = want_dir;
            end
         end else if (item.key_code == dcm_pkg::KEY_A) begin
            smooth_in = !smooth_ff;
            soft_in   = goal_ff;
            rev_in    = 1'b0;
         end
      end else begin
         if (smooth_ff) begin
            tick_in = tick_inc;
            if (tick_inc >= interval_ff) begin
               tick_in = '0;
               // ramp step: finish a reversal at zero, else walk toward goal
               if (rev_ff) begin
                  if (soft_ff == '0 || goal_ff == '0) begin
                     rev_in        = 1'b0;
                     dir_before_in = dir_now_ff;
                  end else begin
                     soft_in = (soft_ff >= dcm_pkg::SPEED_STEP) ?
                               soft_ff - dcm_pkg::SPEED_STEP : '0;
                  end
               end else if (soft_ff > goal_ff) begin
                  soft_in = (soft_ff >= dcm_pkg::SPEED_STEP) ?
                            soft_ff - dcm_pkg::SPEED_STEP : '0;
               end else if (soft_ff < goal_ff) begin
                  soft_in = soft_ff + dcm_pkg::SPEED_STEP;
                  if (soft_in > dcm_pkg::SPEED_MAX) begin
                     soft_in = dcm_pkg::SPEED_MAX;
                  end
               end
            end
         end
         phase_in = (phase_inc[3:0] >= PhaseWrap[3:0] && PhaseWrap[4] == 1'b0) ||
                    phase_inc[4] ? 4'd0 : phase_inc[3:0];
      end
   end

   // pins from the updated state and the phase before this beat
   always_comb begin
      spd     = smooth_in ? soft_in : goal_in;
      pwm     = (phase_ff >= dcm_pkg::speed_div10(spd));
      active  = (goal_in != '0) || (smooth_in && soft_in != '0);
      lvl_dir = rev_in ? dir_before_in : dir_now_in;

      out_in.drive_pins = 3'b000;
      if (active) begin
         if (lvl_dir) begin
            out_in.drive_pins = {1'b1, pwm, 1'b0};
         end else begin
            out_in.drive_pins = {pwm, 1'b1, 1'b0};
         end
      end
      out_in.target_speed = goal_in;
      out_in.ramped_speed = soft_in;
      out_in.spin_reverse = dir_now_in;
      out_in.smooth_on    = smooth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= dcm_pkg::RAMP_RESET;
         goal_ff       <= '0;
         dir_now_ff    <= 1'b0;
         dir_before_ff <= 1'b0;
         smooth_ff     <= 1'b1;
         soft_ff       <= '0;
         rev_ff        <= 1'b0;
         tick_ff       <= '0;
         phase_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            interval_ff <= csr_bus.ramp_interval;
         end
         if (take) begin
            goal_ff       <= goal_in;
            dir_now_ff    <= dir_now_in;
            dir_before_ff <= dir_before_in;
            smooth_ff     <= smooth_in;
            soft_ff       <= soft_in;
            rev_ff        <= rev_in;
            tick_ff       <= tick_in;
            phase_ff      <= phase_in;
            out_valid_ff  <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.drive_pins   = out_ff.drive_pins;
   assign rsp_bus.target_speed = out_ff.target_speed;
   assign rsp_bus.ramped_speed = out_ff.ramped_speed;
   assign rsp_bus.spin_reverse = out_ff.spin_reverse;
   assign rsp_bus.smooth_on    = out_ff.smooth_on;

endmodule

// ===== sv/dc_motor_soft_ramp_pwm_driver.sv =====
// channel   | direction | handshake         | payload
// req_bus   | in        | valid / ready     | func, key_code
// rsp_bus   | out       | valid / ready     | drive_pins, target_speed, ramped_speed,
//           |           |                   | spin_reverse, smooth_on
// csr_bus   | in        | valid / ready (1) | ramp_interval
//
// One item per clock sustained while rsp_bus is ready; a req beat passes through
// the input register, then the result register. The rate is set by the state
// update loop in dcm_core: one beat's update is a single pass of logic from the
// input register to the result register. Synchronous reset clears motor state but
// turns smooth mode on; ramp_interval returns to 200. A stalled rsp_bus holds its
// beat; one more req beat waits in the input register, then req_bus ready stays low until rsp_bus takes its beat.
module dc_motor_soft_ramp_pwm_driver (
   input  logic      clock,
   input  logic      reset,
   dcm_req_if.sink   req_bus,
   dcm_rsp_if.source rsp_bus,
   dcm_csr_if.sink   csr_bus
);

   logic              item_valid;
   logic              take;
   dcm_pkg::item_type item;

   dcm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   dcm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .csr_bus    (csr_bus),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== sv/dcm_checker.sv =====
module dcm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_drive_pins,
   input logic [6:0] rsp_target_speed,
   input logic [6:0] rsp_ramped_speed,
   input logic       rsp_smooth_on
);

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_pins) &&
      $stable(rsp_target_speed) && $stable(rsp_ramped_speed))
      else $error("rsp beat changed while stalled");

   a_target_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_target_speed == 7'd0 || rsp_target_speed == 7'd40 ||
      rsp_target_speed == 7'd50 || rsp_target_speed == 7'd60 ||
      rsp_target_speed == 7'd70 || rsp_target_speed == 7'd80 ||
      rsp_target_speed == 7'd90 || rsp_target_speed == 7'd100)
      else $error("target speed off the key table");

   a_ramp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ramped_speed <= 7'd100)
      else $error("ramped speed above full scale");

   a_pin0_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_drive_pins[0])
      else $error("bridge pin 0 driven");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_speed == 7'd0 && !rsp_smooth_on |-> rsp_drive_pins == 3'd0)
      else $error("bridge driven with no target in direct mode");

endmodule

bind dc_motor_soft_ramp_pwm_driver dcm_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_drive_pins   (rsp_bus.drive_pins),
   .rsp_target_speed (rsp_bus.target_speed),
   .rsp_ramped_speed (rsp_bus.ramped_speed),
   .rsp_smooth_on    (rsp_bus.smooth_on)
);
